// ===== rtl/slkb_pkg.sv =====
`default_nettype none

package slkb_pkg;

   // Depth of the queue between the front and back parts.
   localparam int QueueDepth = 4;
   localparam int QueueCountWidth = 3;
   localparam int QueuePtrWidth = 2;

   localparam logic [7:0]  OpacityReset       = 8'd180;
   localparam logic [7:0]  ThresholdLowReset  = 8'd50;
   localparam logic [7:0]  ThresholdHighReset = 8'd255;
   localparam logic [11:0] FrameWidthReset    = 12'd640;
   localparam logic [11:0] FrameHeightReset   = 12'd480;

   typedef enum logic [2:0] {
      CfgOpacity       = 3'd0,
      CfgThresholdLow  = 3'd1,
      CfgThresholdHigh = 3'd2,
      CfgFrameWidth    = 3'd3,
      CfgFrameHeight   = 3'd4
   } cfg_index_type;

   typedef struct packed {
      logic [7:0] luma;
      logic [7:0] cb;
      logic [7:0] cr;
   } pixel_type;

   typedef struct packed {
      pixel_type  main_px;
      pixel_type  over_px;
      logic       frame_end;
      logic       blend;
      logic [7:0] blur;
   } queue_entry_type;

   typedef struct packed {
      pixel_type main_px;
      pixel_type over_px;
      logic      frame_end;
      logic      blend;
   } back_payload_type;

   typedef struct packed {
      logic [11:0] frame_width;
      logic [11:0] frame_height;
   } front_cfg_type;

   typedef struct packed {
      logic [7:0] opacity;
      logic [7:0] threshold_low;
      logic [7:0] threshold_high;
   } back_cfg_type;

   // Rounded divide by 255 for values up to 255*255.
   function automatic logic [7:0] div255(input logic [16:0] v);
      logic [17:0] t;
      logic [17:0] s;
      t = 18'(v) + 18'd128;
      s = t + (t >> 8);
      return s[15:8];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/slkb_queue.sv =====
`default_nettype none

module slkb_queue (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  push,
   input  wire slkb_pkg::queue_entry_type             push_data,
   input  wire logic                                  pop,
   output slkb_pkg::queue_entry_type                  pop_data,
   output logic                                       empty,
   output logic [slkb_pkg::QueueCountWidth-1:0]       count
);

   logic [slkb_pkg::QueuePtrWidth-1:0]   head_ff, head_in;
   logic [slkb_pkg::QueuePtrWidth-1:0]   tail_ff, tail_in;
   logic [slkb_pkg::QueueCountWidth-1:0] count_ff, count_in;
   slkb_pkg::queue_entry_type            slot_mem [slkb_pkg::QueueDepth];

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push) begin
         tail_in = tail_ff + 1'b1;
      end
      if (pop) begin
         head_in = head_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_mem[tail_ff] <= push_data;
      end
   end

   assign pop_data = slot_mem[head_ff];
   assign empty    = (count_ff == '0);
   assign count    = count_ff;

endmodule

`default_nettype wire

// ===== rtl/slkb_front.sv =====
`default_nettype none

module slkb_front #(
   parameter int MAX_WIDTH = 2048
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic                               req_command,
   input  wire logic [7:0]                         req_main_luma,
   input  wire logic [7:0]                         req_main_cb,
   input  wire logic [7:0]                         req_main_cr,
   input  wire logic [7:0]                         req_over_luma,
   input  wire logic [7:0]                         req_over_cb,
   input  wire logic [7:0]                         req_over_cr,
   input  wire slkb_pkg::front_cfg_type            cfg,
   input  wire logic [slkb_pkg::QueueCountWidth-1:0] q_count,
   output logic                                    q_push,
   output slkb_pkg::queue_entry_type               q_entry
);

   localparam int ColWidth  = $clog2(MAX_WIDTH);
   localparam int WidthBits = $clog2(MAX_WIDTH + 1);
   localparam int Depth     = MAX_WIDTH + 1;
   localparam int PtrWidth  = $clog2(Depth);
   localparam int PendWidth = $clog2(Depth + 1);
   localparam int ProdWidth = 12 + WidthBits;
   localparam int PosWidth  = ProdWidth + 1;

   logic [WidthBits-1:0] eff_w;
   logic [11:0]          eff_h;

   logic [ColWidth-1:0]  col_ff, col_in;
   logic [11:0]          row_ff, row_in;
   logic [PendWidth-1:0] pend_ff, pend_in;
   logic [PtrWidth-1:0]  wptr_ff, wptr_in;
   logic [7:0]           hist0_ff, hist0_in;
   logic [7:0]           hist1_ff, hist1_in;

   logic                 accept;
   logic                 emit;
   logic                 blend_ok;
   logic                 last_col;
   logic                 blur_wr;
   logic                 edge_set;
   logic [31:0]          c32, r32, w32, h32;
   logic [PtrWidth-1:0]  b_mod;
   logic [PtrWidth-1:0]  rd_addr;
   logic [ColWidth-1:0]  blur_addr;
   logic [7:0]           left;
   logic [9:0]           down_sum;
   logic [9:0]           edge_sum;

   // Right-edge entry of a line: written in the following cycle, when the port is free.
   logic                 edge_pend_ff, edge_pend_in;
   logic                 edge_line_ff;
   logic [ColWidth-1:0]  edge_addr_ff;
   logic [7:0]           edge_val_ff;

   logic                 wr0_en, wr1_en;
   logic [ColWidth-1:0]  wr0_addr, wr1_addr;
   logic [7:0]           wr0_data, wr1_data;
   logic [7:0]           line0_mem [MAX_WIDTH];
   logic [7:0]           line1_mem [MAX_WIDTH];
   logic [7:0]           line0_rd_ff, line1_rd_ff;
   logic [47:0]          delay_mem [Depth];
   logic [47:0]          delay_rd_ff;

   logic                 f1_valid_ff, f1_valid_in;
   logic                 f1_line_ff;
   logic [7:0]           f1_down_ff;
   logic [ColWidth-1:0]  f1_col_ff;
   logic [PendWidth-1:0] f1_before_ff;
   logic                 f1_blend_ff;
   logic [ProdWidth-1:0] f1_prod_ff;
   logic [ProdWidth-1:0] frame_ff;

   logic [7:0]           up, mid;
   logic [9:0]           blur_sum;
   logic [PosWidth-1:0]  pos;
   logic [PosWidth-1:0]  pos_next;

   always_comb begin
      if (cfg.frame_width < 12'd3) begin
         eff_w = WidthBits'(3);
      end else if (32'(cfg.frame_width) > MAX_WIDTH) begin
         eff_w = WidthBits'(MAX_WIDTH);
      end else begin
         eff_w = WidthBits'(cfg.frame_width);
      end
      eff_h = (cfg.frame_height < 12'd3) ? 12'd3 : cfg.frame_height;
   end

   // One slot is held back for the word already on its way into the queue.
   assign req_ready = (32'(q_count) + 32'(f1_valid_ff)) < slkb_pkg::QueueDepth;
   assign accept    = req_valid && req_ready;

   always_comb begin
      c32 = 32'(col_ff);
      r32 = 32'(row_ff);
      w32 = 32'(eff_w);
      h32 = 32'(eff_h);
      emit = req_command ? (pend_ff != '0) : (32'(pend_ff) >= w32 + 32'd1);
      b_mod = (32'(pend_ff) == Depth) ? '0 : PtrWidth'(pend_ff);
      if (wptr_ff >= b_mod) begin
         rd_addr = wptr_ff - b_mod;
      end else begin
         rd_addr = PtrWidth'(32'(wptr_ff) + Depth - 32'(b_mod));
      end
      blur_addr = col_ff - ColWidth'(1);
      left      = (col_ff == ColWidth'(1)) ? hist0_ff : hist1_ff;
      down_sum  = 10'(left) + {1'b0, hist0_ff, 1'b0} + 10'(req_main_luma);
      edge_sum  = 10'(hist0_ff) + {1'b0, req_main_luma, 1'b0} + 10'(req_main_luma);
      last_col  = (c32 + 32'd1 >= w32);
      blend_ok  = (c32 >= 32'd2) && (c32 <= w32 - 32'd1) && (r32 >= 32'd2) &&
                  (r32 <= h32 - 32'd1) && (32'(pend_ff) == w32 + 32'd1);
      blur_wr   = accept && !req_command && (col_ff != '0);
      edge_set  = blur_wr && (c32 == w32 - 32'd1);
   end

   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      pend_in  = pend_ff;
      wptr_in  = wptr_ff;
      hist0_in = hist0_ff;
      hist1_in = hist1_ff;
      if (accept) begin
         if (req_command) begin
            if (emit) begin
               pend_in = pend_ff - PendWidth'(1);
            end
         end else begin
            hist1_in = hist0_ff;
            hist0_in = req_main_luma;
            wptr_in  = (32'(wptr_ff) == Depth - 1) ? '0 : wptr_ff + PtrWidth'(1);
            if (!emit && (32'(pend_ff) < Depth)) begin
               pend_in = pend_ff + PendWidth'(1);
            end
            if (last_col) begin
               col_in = '0;
               row_in = (r32 + 32'd1 >= h32) ? '0 : row_ff + 12'd1;
            end else begin
               col_in = col_ff + ColWidth'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         pend_ff      <= '0;
         wptr_ff      <= '0;
         hist0_ff     <= '0;
         hist1_ff     <= '0;
         edge_pend_ff <= 1'b0;
         f1_valid_ff  <= 1'b0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         pend_ff      <= pend_in;
         wptr_ff      <= wptr_in;
         hist0_ff     <= hist0_in;
         hist1_ff     <= hist1_in;
         edge_pend_ff <= edge_pend_in;
         f1_valid_ff  <= f1_valid_in;
      end
   end

   assign edge_pend_in = edge_set;
   assign f1_valid_in  = accept && emit;

   always_ff @(posedge clock) begin
      if (edge_set) begin
         edge_line_ff <= row_ff[0];
         edge_addr_ff <= col_ff;
         edge_val_ff  <= edge_sum[9:2];
      end
      if (accept) begin
         f1_line_ff   <= row_ff[0];
         f1_down_ff   <= down_sum[9:2];
         f1_col_ff    <= col_ff;
         f1_before_ff <= pend_ff;
         f1_blend_ff  <= !req_command && blend_ok;
         f1_prod_ff   <= ProdWidth'(row_ff) * ProdWidth'(eff_w);
      end
      frame_ff <= ProdWidth'(eff_w) * ProdWidth'(eff_h);
   end

   // The deferred right-edge write always finds its line port idle: the word
   // after a line's last pixel starts a new line and writes no blur entry.
   always_comb begin
      wr0_en   = (blur_wr && !row_ff[0]) || (edge_pend_ff && !edge_line_ff);
      wr1_en   = (blur_wr && row_ff[0]) || (edge_pend_ff && edge_line_ff);
      wr0_addr = (blur_wr && !row_ff[0]) ? blur_addr : edge_addr_ff;
      wr1_addr = (blur_wr && row_ff[0]) ? blur_addr : edge_addr_ff;
      wr0_data = (blur_wr && !row_ff[0]) ? down_sum[9:2] : edge_val_ff;
      wr1_data = (blur_wr && row_ff[0]) ? down_sum[9:2] : edge_val_ff;
   end

   always_ff @(posedge clock) begin
      if (wr0_en) begin
         line0_mem[wr0_addr] <= wr0_data;
      end
      if (accept) begin
         line0_rd_ff <= line0_mem[blur_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr1_en) begin
         line1_mem[wr1_addr] <= wr1_data;
      end
      if (accept) begin
         line1_rd_ff <= line1_mem[blur_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (accept && !req_command) begin
         delay_mem[wptr_ff] <= {req_main_luma, req_main_cb, req_main_cr,
                                req_over_luma, req_over_cb, req_over_cr};
      end
      if (accept) begin
         delay_rd_ff <= delay_mem[rd_addr];
      end
   end

   always_comb begin
      up       = f1_line_ff ? line1_rd_ff : line0_rd_ff;
      mid      = f1_line_ff ? line0_rd_ff : line1_rd_ff;
      blur_sum = 10'(up) + {1'b0, mid, 1'b0} + 10'(f1_down_ff);
      pos      = PosWidth'(f1_prod_ff) + PosWidth'(f1_col_ff);
      pos_next = pos + PosWidth'(1);
      q_push   = f1_valid_ff;
      q_entry.main_px   = slkb_pkg::pixel_type'(delay_rd_ff[47:24]);
      q_entry.over_px   = slkb_pkg::pixel_type'(delay_rd_ff[23:0]);
      q_entry.frame_end = (pos_next == PosWidth'(f1_before_ff) + PosWidth'(frame_ff)) ||
                          (pos_next == PosWidth'(f1_before_ff));
      q_entry.blend     = f1_blend_ff;
      q_entry.blur      = blur_sum[9:2];
   end

endmodule

`default_nettype wire

// ===== rtl/slkb_back.sv =====
`default_nettype none

module slkb_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire slkb_pkg::back_cfg_type      cfg,
   input  wire logic                        q_empty,
   input  wire slkb_pkg::queue_entry_type   q_data,
   output logic                             q_pop,
   input  wire logic                        rsp_ready,
   output logic                             rsp_valid,
   output logic [7:0]                       rsp_out_luma,
   output logic [7:0]                       rsp_out_cb,
   output logic [7:0]                       rsp_out_cr,
   output logic                             rsp_frame_end
);

   localparam int DivSteps = 8;

   logic       en;
   logic [7:0] lo, hi, diff;
   logic [7:0] off;

   logic                           dv_valid_ff [DivSteps+1];
   logic                           dv_valid_in [DivSteps+1];
   slkb_pkg::back_payload_type     dv_pay_ff   [DivSteps+1];
   slkb_pkg::back_payload_type     dv_pay_in   [DivSteps+1];
   logic [15:0]                    dv_rem_ff   [DivSteps+1];
   logic [15:0]                    dv_rem_in   [DivSteps+1];
   logic [7:0]                     dv_q_ff     [DivSteps+1];
   logic [7:0]                     dv_q_in     [DivSteps+1];
   logic                           dv_zero_ff  [DivSteps+1];
   logic                           dv_zero_in  [DivSteps+1];
   logic                           dv_full_ff  [DivSteps+1];
   logic                           dv_full_in  [DivSteps+1];

   logic                           m_valid_ff;
   slkb_pkg::back_payload_type     m_pay_ff;
   logic [15:0]                    m_prod_ff, m_prod_in;
   logic [7:0]                     mask;

   logic                           w_valid_ff;
   slkb_pkg::back_payload_type     w_pay_ff;
   logic [7:0]                     w_w2_ff;

   logic                           b_valid_ff;
   slkb_pkg::back_payload_type     b_pay_ff;
   logic [7:0]                     b_w2_ff;
   logic [16:0]                    b_luma_ff, b_cb_ff, b_cr_ff;
   logic [16:0]                    b_luma_in, b_cb_in, b_cr_in;
   logic [7:0]                     w1;

   logic                           out_valid_ff;
   logic [7:0]                     out_luma_ff, out_luma_in;
   logic [7:0]                     out_cb_ff, out_cb_in;
   logic [7:0]                     out_cr_ff, out_cr_in;
   logic                           out_fe_ff;

   // The whole back pipeline moves together and freezes while the output waits.
   assign en    = !out_valid_ff || rsp_ready;
   assign q_pop = en && !q_empty;

   always_comb begin
      if (cfg.threshold_high < cfg.threshold_low) begin
         lo = cfg.threshold_high;
         hi = cfg.threshold_low;
      end else begin
         lo = cfg.threshold_low;
         hi = cfg.threshold_high;
      end
      diff = (hi > lo) ? hi - lo : 8'd1;
      off  = q_data.blur - lo;
   end

   // Stage 0 forms the ramp numerator, stages 1 to 8 find one quotient bit each.
   always_comb begin
      logic [15:0] shifted;
      dv_valid_in[0]         = !q_empty;
      dv_pay_in[0].main_px   = q_data.main_px;
      dv_pay_in[0].over_px   = q_data.over_px;
      dv_pay_in[0].frame_end = q_data.frame_end;
      dv_pay_in[0].blend     = q_data.blend;
      dv_rem_in[0]  = {off, 8'd0} - 16'(off) + 16'(diff >> 1);
      dv_q_in[0]    = '0;
      dv_zero_in[0] = (q_data.blur <= lo);
      dv_full_in[0] = (q_data.blur >= hi);
      for (int k = 1; k <= DivSteps; k++) begin
         shifted        = 16'(diff) << (DivSteps - k);
         dv_valid_in[k] = dv_valid_ff[k-1];
         dv_pay_in[k]   = dv_pay_ff[k-1];
         dv_zero_in[k]  = dv_zero_ff[k-1];
         dv_full_in[k]  = dv_full_ff[k-1];
         if (dv_rem_ff[k-1] >= shifted) begin
            dv_rem_in[k] = dv_rem_ff[k-1] - shifted;
            dv_q_in[k]   = dv_q_ff[k-1] | (8'd1 << (DivSteps - k));
         end else begin
            dv_rem_in[k] = dv_rem_ff[k-1];
            dv_q_in[k]   = dv_q_ff[k-1];
         end
      end
   end

   always_comb begin
      if (dv_zero_ff[DivSteps]) begin
         mask = 8'd0;
      end else if (dv_full_ff[DivSteps]) begin
         mask = 8'd255;
      end else begin
         mask = dv_q_ff[DivSteps];
      end
      m_prod_in = 16'(mask) * 16'(cfg.opacity);
      w1        = 8'd255 - w_w2_ff;
      b_luma_in = 17'(w1) * 17'(w_pay_ff.main_px.luma) +
                  17'(w_w2_ff) * 17'(w_pay_ff.over_px.luma);
      b_cb_in   = 17'(w1) * 17'(w_pay_ff.main_px.cb) +
                  17'(w_w2_ff) * 17'(w_pay_ff.over_px.cb);
      b_cr_in   = 17'(w1) * 17'(w_pay_ff.main_px.cr) +
                  17'(w_w2_ff) * 17'(w_pay_ff.over_px.cr);
      if (b_pay_ff.blend && (b_w2_ff != 8'd0)) begin
         out_luma_in = slkb_pkg::div255(b_luma_ff);
         out_cb_in   = slkb_pkg::div255(b_cb_ff);
         out_cr_in   = slkb_pkg::div255(b_cr_ff);
      end else begin
         out_luma_in = b_pay_ff.main_px.luma;
         out_cb_in   = b_pay_ff.main_px.cb;
         out_cr_in   = b_pay_ff.main_px.cr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= DivSteps; k++) begin
            dv_valid_ff[k] <= 1'b0;
         end
         m_valid_ff   <= 1'b0;
         w_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         for (int k = 0; k <= DivSteps; k++) begin
            dv_valid_ff[k] <= dv_valid_in[k];
         end
         m_valid_ff   <= dv_valid_ff[DivSteps];
         w_valid_ff   <= m_valid_ff;
         b_valid_ff   <= w_valid_ff;
         out_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k <= DivSteps; k++) begin
            dv_pay_ff[k]  <= dv_pay_in[k];
            dv_rem_ff[k]  <= dv_rem_in[k];
            dv_q_ff[k]    <= dv_q_in[k];
            dv_zero_ff[k] <= dv_zero_in[k];
            dv_full_ff[k] <= dv_full_in[k];
         end
         m_pay_ff    <= dv_pay_ff[DivSteps];
         m_prod_ff   <= m_prod_in;
         w_pay_ff    <= m_pay_ff;
         w_w2_ff     <= slkb_pkg::div255(17'(m_prod_ff));
         b_pay_ff    <= w_pay_ff;
         b_w2_ff     <= w_w2_ff;
         b_luma_ff   <= b_luma_in;
         b_cb_ff     <= b_cb_in;
         b_cr_ff     <= b_cr_in;
         out_luma_ff <= out_luma_in;
         out_cb_ff   <= out_cb_in;
         out_cr_ff   <= out_cr_in;
         out_fe_ff   <= b_pay_ff.frame_end;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_out_luma  = out_luma_ff;
   assign rsp_out_cb    = out_cb_ff;
   assign rsp_out_cr    = out_cr_ff;
   assign rsp_frame_end = out_fe_ff;

endmodule

`default_nettype wire

// ===== rtl/soft_luma_key_blend.sv =====
// Soft luma key blend of an overlay frame onto a main frame, 4:4:4 YCbCr.
// Input channel (req_*): one word per pixel pair in raster order, or a drain
// word (req_command high) that releases one held pixel at the end of a stream.
// Result channel (rsp_*): the blended pixel that entered width+1 pixel words
// earlier, with rsp_frame_end marking the last pixel of a frame. A pixel word
// that only fills the delay line, and a drain word with nothing held, give
// no result word.
// Configuration (APB): opacity, thresholds and frame size at byte addresses
// 0, 4, 8, 12 and 16; write them only while the block is idle.
// The block takes one word per clock while req_ready is high. A result word
// passes the front part's register (position and memory read), the queue,
// and the back part's registers: ramp numerator, ramp divider stages, weight
// product, weight, blend products and the output register.
// Reset clears the position, the delay line fill and all pipeline valids and
// loads the register defaults. When the receiver stalls, the back part
// freezes, the four-word queue absorbs the front part, and req_ready falls
// once the queue has no room left.
`default_nettype none

module soft_luma_key_blend #(
   parameter int MAX_WIDTH = 2048
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_command,
   input  wire logic [7:0]  req_main_luma,
   input  wire logic [7:0]  req_main_cb,
   input  wire logic [7:0]  req_main_cr,
   input  wire logic [7:0]  req_over_luma,
   input  wire logic [7:0]  req_over_cb,
   input  wire logic [7:0]  req_over_cr,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_out_luma,
   output logic [7:0]       rsp_out_cb,
   output logic [7:0]       rsp_out_cr,
   output logic             rsp_frame_end,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [4:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   // Configuration registers.
   logic [7:0]  opacity_ff, opacity_in;
   logic [7:0]  thr_low_ff, thr_low_in;
   logic [7:0]  thr_high_ff, thr_high_in;
   logic [11:0] frame_width_ff, frame_width_in;
   logic [11:0] frame_height_ff, frame_height_in;

   logic                     csr_write;
   slkb_pkg::cfg_index_type  csr_index;
   slkb_pkg::front_cfg_type  front_cfg;
   slkb_pkg::back_cfg_type   back_cfg;

   // Queue between the front and back parts.
   logic                                 q_push;
   logic                                 q_pop;
   logic                                 q_empty;
   logic [slkb_pkg::QueueCountWidth-1:0] q_count;
   slkb_pkg::queue_entry_type            q_entry;
   slkb_pkg::queue_entry_type            q_head;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = slkb_pkg::cfg_index_type'(paddr[4:2]);

   always_comb begin
      opacity_in      = opacity_ff;
      thr_low_in      = thr_low_ff;
      thr_high_in     = thr_high_ff;
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_write) begin
         case (csr_index)
            slkb_pkg::CfgOpacity:       opacity_in      = pwdata[7:0];
            slkb_pkg::CfgThresholdLow:  thr_low_in      = pwdata[7:0];
            slkb_pkg::CfgThresholdHigh: thr_high_in     = pwdata[7:0];
            slkb_pkg::CfgFrameWidth:    frame_width_in  = pwdata[11:0];
            slkb_pkg::CfgFrameHeight:   frame_height_in = pwdata[11:0];
            default:                    opacity_in      = opacity_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         opacity_ff      <= slkb_pkg::OpacityReset;
         thr_low_ff      <= slkb_pkg::ThresholdLowReset;
         thr_high_ff     <= slkb_pkg::ThresholdHighReset;
         frame_width_ff  <= slkb_pkg::FrameWidthReset;
         frame_height_ff <= slkb_pkg::FrameHeightReset;
      end else begin
         opacity_ff      <= opacity_in;
         thr_low_ff      <= thr_low_in;
         thr_high_ff     <= thr_high_in;
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
      end
   end

   // Reads return the stored value; addresses past the last register read zero.
   always_comb begin
      case (csr_index)
         slkb_pkg::CfgOpacity:       prdata = 32'(opacity_ff);
         slkb_pkg::CfgThresholdLow:  prdata = 32'(thr_low_ff);
         slkb_pkg::CfgThresholdHigh: prdata = 32'(thr_high_ff);
         slkb_pkg::CfgFrameWidth:    prdata = 32'(frame_width_ff);
         slkb_pkg::CfgFrameHeight:   prdata = 32'(frame_height_ff);
         default:                    prdata = 32'd0;
      endcase
   end

   always_comb begin
      front_cfg.frame_width   = frame_width_ff;
      front_cfg.frame_height  = frame_height_ff;
      back_cfg.opacity        = opacity_ff;
      back_cfg.threshold_low  = thr_low_ff;
      back_cfg.threshold_high = thr_high_ff;
   end

   // The front part tracks the raster position, keeps the two blur lines and
   // the pixel delay line, and queues every word that yields a result.
   slkb_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_command   (req_command),
      .req_main_luma (req_main_luma),
      .req_main_cb   (req_main_cb),
      .req_main_cr   (req_main_cr),
      .req_over_luma (req_over_luma),
      .req_over_cb   (req_over_cb),
      .req_over_cr   (req_over_cr),
      .cfg           (front_cfg),
      .q_count       (q_count),
      .q_push        (q_push),
      .q_entry       (q_entry)
   );

   slkb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_entry),
      .pop       (q_pop),
      .pop_data  (q_head),
      .empty     (q_empty),
      .count     (q_count)
   );

   // The back part turns the blurred luma into a weight and blends.
   slkb_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (back_cfg),
      .q_empty       (q_empty),
      .q_data        (q_head),
      .q_pop         (q_pop),
      .rsp_ready     (rsp_ready),
      .rsp_valid     (rsp_valid),
      .rsp_out_luma  (rsp_out_luma),
      .rsp_out_cb    (rsp_out_cb),
      .rsp_out_cr    (rsp_out_cr),
      .rsp_frame_end (rsp_frame_end)
   );

   // The front part's credit check must keep the queue from ever overflowing.
   a_queue_room: assert property (@(posedge clock) disable iff (reset)
      q_push |-> (32'(q_count) != slkb_pkg::QueueDepth))
      else $error("queue written while full");

   // A queued word always stems from a word accepted in the previous cycle.
   a_push_after_accept: assert property (@(posedge clock) disable iff (reset)
      q_push |-> $past(req_valid && req_ready))
      else $error("queue written without an accepted input word");

   // A stalled output must hold the back part, so nothing leaves the queue.
   a_stall_holds_queue: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !q_pop)
      else $error("queue read while the output is stalled");

endmodule

`default_nettype wire

// ===== sim/soft_luma_key_blend_tb.sv =====
`default_nettype none

module soft_luma_key_blend_tb;

   // Cycles without any word moving on either channel before the run is
   // declared hung. Configuration pauses and the end wait stay far below it.
   localparam int unsigned HangLimit = 5000;
   // Pause after the last expected word before registers are rewritten, so
   // that a trailing pixel word still inside the pipeline has left it.
   localparam int unsigned SettleCycles = 24;
   localparam int unsigned LineMax = 2048;
   localparam int unsigned DelayDepth = LineMax + 1;

   typedef struct packed {
      logic       drain;
      logic [7:0] main_luma;
      logic [7:0] main_cb;
      logic [7:0] main_cr;
      logic [7:0] over_luma;
      logic [7:0] over_cb;
      logic [7:0] over_cr;
   } word_type;

   typedef struct packed {
      logic [7:0] luma;
      logic [7:0] cb;
      logic [7:0] cr;
      logic       frame_end;
   } blend_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_command = 1'b0;
   logic [7:0]  req_main_luma = '0;
   logic [7:0]  req_main_cb = '0;
   logic [7:0]  req_main_cr = '0;
   logic [7:0]  req_over_luma = '0;
   logic [7:0]  req_over_cb = '0;
   logic [7:0]  req_over_cr = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_out_luma;
   logic [7:0]  rsp_out_cb;
   logic [7:0]  rsp_out_cr;
   logic        rsp_frame_end;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [4:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   soft_luma_key_blend i_dut (.*);

   always #5 clock = ~clock;

   // Words waiting to be sent, and blended pixels waiting to come back.
   word_type  send_q[$];
   blend_type blend_q[$];
   word_type  cur_word;
   int unsigned errors = 0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned hang_count = 0;

   // Predictor copy of the registers.
   int unsigned opacity_reg = slkb_pkg::OpacityReset;
   int unsigned thr_low_reg = slkb_pkg::ThresholdLowReset;
   int unsigned thr_high_reg = slkb_pkg::ThresholdHighReset;
   int unsigned width_reg = slkb_pkg::FrameWidthReset;
   int unsigned height_reg = slkb_pkg::FrameHeightReset;

   // Predictor copy of the block's state.
   int unsigned luma_last = 0;
   int unsigned luma_prev = 0;
   logic [7:0]  hblur_mem [0:2*LineMax-1] = '{default: 8'd0};
   logic [47:0] delay_mem [0:DelayDepth-1] = '{default: 48'd0};
   int unsigned col_pos = 0;
   int unsigned row_pos = 0;
   int unsigned held = 0;
   int unsigned wr_ptr = 0;

   function automatic int unsigned round_div255(input int unsigned v);
      int unsigned t;
      t = v + 128;
      return ((t + (t >> 8)) >> 8) & 255;
   endfunction

   function automatic int unsigned active_width();
      if (width_reg < 3) return 3;
      if (width_reg > LineMax) return LineMax;
      return width_reg;
   endfunction

   // Overlay weight from the vertically blurred luma.
   function automatic int unsigned key_weight(input int unsigned blur);
      int unsigned lo, hi, diff, mask;
      lo = thr_low_reg;
      hi = thr_high_reg;
      if (hi < lo) begin
         lo = thr_high_reg;
         hi = thr_low_reg;
      end
      diff = (hi > lo) ? hi - lo : 1;
      if (blur <= lo) mask = 0;
      else if (blur >= hi) mask = 255;
      else mask = ((blur - lo) * 255 + (diff >> 1)) / diff;
      return round_div255(mask * opacity_reg);
   endfunction

   // The emitted pixel sits "behind" words back from the current position.
   function automatic logic ends_frame(input int unsigned pos, input int unsigned behind,
                                       input int unsigned w, input int unsigned h);
      int unsigned area, last;
      area = w * h;
      last = (pos >= behind) ? pos - behind : pos + area - behind;
      return last == area - 1;
   endfunction

   // Advances the predicted state by one accepted word and queues the pixel
   // that it releases, if any.
   function automatic void blend_word(input word_type wd);
      int unsigned w, h, c, r, pos, prior, rd, cur, up, mid, down, left, line, w2;
      logic [47:0] px;
      logic        have_blur, emit;
      blend_type   res;
      w = active_width();
      h = (height_reg < 3) ? 3 : height_reg;
      c = col_pos;
      r = row_pos;
      pos = r * w + c;
      prior = held;
      rd = (wr_ptr + DelayDepth - (prior % DelayDepth)) % DelayDepth;
      up = 0;
      mid = 0;
      down = 0;
      have_blur = 1'b0;
      if (wd.drain) begin
         // A drain word releases the oldest held pixel untouched.
         if (prior == 0) return;
         px = delay_mem[rd];
         res = '{px[47:40], px[39:32], px[31:24], ends_frame(pos, prior, w, h)};
         held = prior - 1;
         blend_q.push_back(res);
         return;
      end
      cur = wd.main_luma;
      if (c >= 1 && c - 1 < LineMax) begin
         // Horizontal blur of the previous column; the line store holds two rows.
         line = r & 1;
         left = (c == 1) ? luma_last : luma_prev;
         down = (left + 2 * luma_last + cur) >> 2;
         up = hblur_mem[line * LineMax + c - 1];
         mid = hblur_mem[(line ^ 1) * LineMax + c - 1];
         hblur_mem[line * LineMax + c - 1] = down[7:0];
         have_blur = 1'b1;
         // The right edge column replicates its own pixel.
         if (c == w - 1 && c < LineMax) begin
            hblur_mem[line * LineMax + c] = 8'((luma_last + 3 * cur) >> 2);
         end
      end
      luma_prev = luma_last;
      luma_last = cur;
      emit = prior >= w + 1;
      if (emit) px = delay_mem[rd];
      delay_mem[wr_ptr] = {wd.main_luma, wd.main_cb, wd.main_cr,
                           wd.over_luma, wd.over_cb, wd.over_cr};
      wr_ptr = (wr_ptr + 1) % DelayDepth;
      if (!emit && held < DelayDepth) held = prior + 1;
      if (c + 1 >= w) begin
         col_pos = 0;
         row_pos = (r + 1 >= h) ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
      end
      if (!emit) return;
      res = '{px[47:40], px[39:32], px[31:24], ends_frame(pos, prior, w, h)};
      // Border pixels, a partly filled delay line and a zero weight pass through.
      if (have_blur && prior == w + 1 && c >= 2 && c <= w - 1 && r >= 2 && r <= h - 1) begin
         w2 = key_weight((up + 2 * mid + down) >> 2);
         if (w2 > 0) begin
            res.luma = 8'(round_div255((255 - w2) * px[47:40] + w2 * px[23:16]));
            res.cb = 8'(round_div255((255 - w2) * px[39:32] + w2 * px[15:8]));
            res.cr = 8'(round_div255((255 - w2) * px[31:24] + w2 * px[7:0]));
         end
      end
      blend_q.push_back(res);
   endfunction

   // Driver: a word is predicted when it is accepted, and the next one is
   // offered unless the sender chooses to idle this cycle.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) blend_word(cur_word);
         if (!req_valid || req_ready) begin
            if (send_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               cur_word = send_q.pop_front();
               req_valid <= 1'b1;
               req_command <= cur_word.drain;
               req_main_luma <= cur_word.main_luma;
               req_main_cb <= cur_word.main_cb;
               req_main_cr <= cur_word.main_cr;
               req_over_luma <= cur_word.over_luma;
               req_over_cb <= cur_word.over_cb;
               req_over_cr <= cur_word.over_cr;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: every accepted result word is matched against the oldest
   // predicted pixel, field by field.
   always @(posedge clock) begin
      blend_type exp_px;
      if (!reset) begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         if (rsp_valid && rsp_ready) begin
            if (blend_q.size() == 0) begin
               $error("unexpected result word: luma %0d cb %0d cr %0d",
                      rsp_out_luma, rsp_out_cb, rsp_out_cr);
               errors++;
            end else begin
               exp_px = blend_q.pop_front();
               if (rsp_out_luma !== exp_px.luma) begin
                  $error("out_luma: expected %0d, got %0d", exp_px.luma, rsp_out_luma);
                  errors++;
               end
               if (rsp_out_cb !== exp_px.cb) begin
                  $error("out_cb: expected %0d, got %0d", exp_px.cb, rsp_out_cb);
                  errors++;
               end
               if (rsp_out_cr !== exp_px.cr) begin
                  $error("out_cr: expected %0d, got %0d", exp_px.cr, rsp_out_cr);
                  errors++;
               end
               if (rsp_frame_end !== exp_px.frame_end) begin
                  $error("frame_end: expected %0d, got %0d", exp_px.frame_end,
                         rsp_frame_end);
                  errors++;
               end
            end
         end
      end
   end

   // Watchdog: a long stretch with no word moving means the block is hung.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         hang_count <= 0;
      end else begin
         hang_count <= hang_count + 1;
         if (hang_count >= HangLimit) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // APB write: setup cycle, then an access cycle in which the register takes
   // the value. The predictor copy follows at the same edge.
   task automatic write_reg(input slkb_pkg::cfg_index_type idx, input int unsigned value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         slkb_pkg::CfgOpacity:       opacity_reg = value & 255;
         slkb_pkg::CfgThresholdLow:  thr_low_reg = value & 255;
         slkb_pkg::CfgThresholdHigh: thr_high_reg = value & 255;
         slkb_pkg::CfgFrameWidth:    width_reg = value & 4095;
         slkb_pkg::CfgFrameHeight:   height_reg = value & 4095;
         default: ;
      endcase
   endtask

   task automatic set_config(input int unsigned op, input int unsigned lo,
                             input int unsigned hi, input int unsigned w,
                             input int unsigned h);
      write_reg(slkb_pkg::CfgOpacity, op);
      write_reg(slkb_pkg::CfgThresholdLow, lo);
      write_reg(slkb_pkg::CfgThresholdHigh, hi);
      write_reg(slkb_pkg::CfgFrameWidth, w);
      write_reg(slkb_pkg::CfgFrameHeight, h);
   endtask

   // Waits until every word is sent and every pixel has come back, then lets
   // trailing pixel words that release nothing leave the pipeline.
   task automatic wait_idle();
      while (send_q.size() > 0 || req_valid || blend_q.size() > 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   function automatic void push_word(input logic drain, input int unsigned luma,
                                     input int unsigned cb, input int unsigned cr,
                                     input int unsigned oluma, input int unsigned ocb,
                                     input int unsigned ocr);
      send_q.push_back('{drain, 8'(luma), 8'(cb), 8'(cr), 8'(oluma), 8'(ocb), 8'(ocr)});
   endfunction

   // Luma is either an extreme, near a per-frame level so the blur lands on
   // the ramp, or uniform. Chroma is uniform.
   function automatic void push_pixel(input int unsigned level);
      int unsigned luma;
      case ($urandom_range(3))
         0: luma = $urandom_range(1) ? 255 : 0;
         1: luma = (level + $urandom_range(40)) % 256;
         default: luma = $urandom_range(255);
      endcase
      push_word(1'b0, luma, $urandom_range(255), $urandom_range(255),
                $urandom_range(255), $urandom_range(255), $urandom_range(255));
   endfunction

   function automatic void push_drains(input int unsigned n);
      repeat (n) push_word(1'b1, $urandom_range(255), $urandom_range(255),
                           $urandom_range(255), $urandom_range(255),
                           $urandom_range(255), $urandom_range(255));
   endfunction

   function automatic int unsigned pick_level();
      case ($urandom_range(3))
         0: return 0;
         1: return 255;
         default: return $urandom_range(255);
      endcase
   endfunction

   initial begin
      int unsigned phase, sent, w, h, frames, level, lines;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed frame: smallest size, swapped thresholds, extreme pixels,
      // drains with nothing held, a truncated frame drained early and then
      // completed.
      send_idle_pct = 64;
      set_config(255, 255, 0, 3, 3);
      push_drains(2);
      for (int i = 0; i < 9; i++) begin
         push_word(1'b0, (i % 2) ? 255 : 0, (i % 3) ? 0 : 255, (i % 2) ? 0 : 255,
                   (i % 2) ? 0 : 255, (i % 3) ? 255 : 0, (i % 2) ? 255 : 0);
      end
      push_drains(5);
      for (int i = 0; i < 5; i++) push_pixel(128);
      push_drains(6);
      for (int i = 0; i < 4; i++) push_pixel(128);
      push_drains(2);
      wait_idle();

      // Random phases: each writes every register, sends whole frames with an
      // occasional drain in the middle, and flushes the delay line at the end.
      // Widths and heights below three act as three.
      phase = 0;
      sent = 0;
      while (sent < 1100) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
            default: begin send_idle_pct = 35; recv_stall_pct = 35; end
         endcase
         w = $urandom_range(10);
         h = $urandom_range(6);
         set_config(pick_level(), pick_level(), pick_level(), w, h);
         w = active_width();
         h = (height_reg < 3) ? 3 : height_reg;
         frames = $urandom_range(1, 3);
         for (int f = 0; f < frames; f++) begin
            level = pick_level();
            for (int i = 0; i < w * h; i++) begin
               if ($urandom_range(99) < 3) begin
                  push_drains(1);
                  sent++;
               end
               push_pixel(level);
               sent++;
            end
         end
         push_drains(w + 3);
         sent += w + 3;
         wait_idle();
         phase++;
      end

      // Tallest frame allowed, cut short: only its first lines are sent.
      send_idle_pct = 35;
      recv_stall_pct = 35;
      set_config(200, 20, 230, 3, 4095);
      lines = 40;
      level = pick_level();
      repeat (lines * 3) push_pixel(level);
      push_drains(6);

      while (send_q.size() > 0 || req_valid || blend_q.size() > 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/slkb_pkg.sv
rtl/slkb_queue.sv
rtl/slkb_front.sv
rtl/slkb_back.sv
rtl/soft_luma_key_blend.sv
sim/soft_luma_key_blend_tb.sv
